### rtl/core/iir_bandpass_filter_bank_defines.svh
// ----------------------------------------------------------------------------
// iir bandpass filter bank assertion macros
// Shared property wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef IIR_BANDPASS_FILTER_BANK_DEFINES_SVH
`define IIR_BANDPASS_FILTER_BANK_DEFINES_SVH

// same-cycle implication
`define IBF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IBF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/ibf_pkg.sv
// ----------------------------------------------------------------------------
// ibf_pkg
// Widths, op codes and saturation helpers of the iir bandpass filter bank.
// ----------------------------------------------------------------------------
`default_nettype none

package ibf_pkg;

  // bank geometry
  localparam int NUM_BANDS = 8;
  localparam int TAPS      = 8;
  localparam int BAND_W    = 3;
  localparam int TAP_W     = 3;
  localparam int HIST_AW   = BAND_W + TAP_W;
  localparam int STEP_W    = TAP_W + 1;

  // datapath widths
  localparam int VAL_W     = 32;
  localparam int HIST_W    = 48;
  localparam int ACC_W     = 60;
  localparam int SUM_W     = 52;
  localparam int SPLIT     = 24;
  localparam int OPB_W     = 29;
  localparam int PROD_W    = VAL_W + OPB_W;
  localparam int FULL_W    = 84;
  localparam int COEF_FRAC = 23;
  localparam int GAIN_FRAC = 31;
  localparam int Y_W       = FULL_W - GAIN_FRAC;
  localparam int OUT_W     = 40;
  localparam int CFG_W     = 4;

  // op codes
  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_COEF   = 2'd1;
  localparam logic [1:0] OP_GAIN   = 2'd2;

  // saturate accumulator to history width
  function automatic logic signed [HIST_W-1:0] sat_hist(input logic signed [ACC_W-1:0] v);
    logic [HIST_W-1:0] r;
    if (v[ACC_W-1:HIST_W-1] == {(ACC_W-HIST_W+1){v[ACC_W-1]}}) begin
      r = v[HIST_W-1:0];
    end else if (v[ACC_W-1]) begin
      r = {1'b1, {(HIST_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(HIST_W-1){1'b1}}};
    end
    return r;
  endfunction

  // saturate scaled band output to output width
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [Y_W-1:0] v);
    logic [OUT_W-1:0] r;
    if (v[Y_W-1:OUT_W-1] == {(Y_W-OUT_W+1){v[Y_W-1]}}) begin
      r = v[OUT_W-1:0];
    end else if (v[Y_W-1]) begin
      r = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(OUT_W-1){1'b1}}};
    end
    return r;
  endfunction

  // index of the last band in use; zero counts as one band
  function automatic logic [BAND_W-1:0] last_band_of(input logic [CFG_W-1:0] n);
    logic [BAND_W-1:0] r;
    if (n == '0) begin
      r = '0;
    end else if (32'(n) > NUM_BANDS) begin
      r = BAND_W'(NUM_BANDS - 1);
    end else begin
      r = BAND_W'(n - 1'b1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/iir_bandpass_filter_bank.sv
// ----------------------------------------------------------------------------
// iir_bandpass_filter_bank
// Bank of 8th-order direct-form-II bandpass filters on one shared sample.
// ----------------------------------------------------------------------------
// Usage:
//   input words carry op, band, tap and value; a word is taken when in_valid
//   is high and in_stall low. Coefficient and gain writes give no output. A
//   sample word yields one output word per active band, band 0 first, with
//   last set on the final band. The user must write active_bands through
//   cfg_we / cfg_wdata only while the bank is idle; the bank does not enforce it.
// Band sequence:
//   each band runs the eight a_k * w_k products, which go through the single
//   32x29 multiplier in two halves each, drains the multiply-accumulate
//   pipe, updates the history, runs the gain product in two halves and
//   drains it. No new word is taken until the last band of a sample is done.
// Reset:
//   rst clears the history (through per-entry valid bits), the ring pointers
//   and sets active_bands to 8. Coefficients and gains must be loaded.
// Stall:
//   a pending output word is held while out_stall is high; the gain product
//   of the next band is not started until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none
`include "iir_bandpass_filter_bank_defines.svh"

module iir_bandpass_filter_bank
  import ibf_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_W-1:0]         cfg_wdata,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [1:0]               op,
  input  wire logic [BAND_W-1:0]        band,
  input  wire logic [TAP_W-1:0]         tap,
  input  wire logic signed [VAL_W-1:0]  value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [BAND_W-1:0]             out_band,
  output logic signed [OUT_W-1:0]       filtered,
  output logic                          last
);

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_TAPS      = 7'b0000010,
    ST_DRAIN_ACC = 7'b0000100,
    ST_UPDATE    = 7'b0001000,
    ST_GAIN_HI   = 7'b0010000,
    ST_GAIN_LO   = 7'b0100000,
    ST_DRAIN_OUT = 7'b1000000
  } state_t;

  // control state
  state_t              state;
  logic [CFG_W-1:0]    active_bands;
  logic [BAND_W-1:0]   cur_band;
  logic [BAND_W-1:0]   last_band;
  logic [STEP_W-1:0]   step;
  logic [TAP_W-1:0]    head [NUM_BANDS];
  logic                hist_valid [NUM_BANDS*TAPS];
  logic                hist_vq;

  // pipeline tags
  logic                s1_valid, s1_gain, s1_lo;
  logic [TAP_W-1:0]    s1_tap;
  logic                s2_valid, s2_gain, s2_lo;
  logic                s3_valid, s3_gain;
  logic                s3_last;
  logic [BAND_W-1:0]   s3_band;

  // memories and read data
  logic signed [HIST_W-1:0] hist_mem [NUM_BANDS*TAPS];
  logic signed [VAL_W-1:0]  coef_mem [NUM_BANDS*TAPS];
  logic signed [VAL_W-1:0]  gain_mem [NUM_BANDS];
  logic signed [HIST_W-1:0] hist_q;
  logic signed [VAL_W-1:0]  coef_q;
  logic signed [VAL_W-1:0]  gain_q;

  // datapath registers
  logic signed [VAL_W-1:0]  x;
  logic signed [ACC_W-1:0]  acc;
  logic signed [SUM_W-1:0]  s_acc;
  logic signed [SUM_W-1:0]  s_sum;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_hi;
  logic signed [FULL_W-1:0] full;

  // combinational
  logic                     in_take;
  logic                     out_free;
  logic                     pipe_empty;
  logic                     issue, issue_gain, issue_lo;
  logic                     hist_re;
  logic [TAP_W-1:0]         step_tap;
  logic [HIST_AW-1:0]       hist_raddr;
  logic [HIST_AW-1:0]       hist_waddr;
  logic [HIST_AW-1:0]       coef_raddr;
  logic [TAP_W-1:0]         head_dec;
  logic signed [HIST_W-1:0] h_cur;
  logic signed [SUM_W-1:0]  h_ext;
  logic signed [HIST_W-1:0] w_new;
  logic signed [PROD_W-1:0] opa_ext;
  logic signed [PROD_W-1:0] opb_ext;
  logic signed [OPB_W-1:0]  opb;
  logic signed [FULL_W-1:0] full_next;

  // handshake and issue control
  assign in_stall   = (state != ST_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign pipe_empty = !s1_valid && !s2_valid && !s3_valid;
  assign step_tap   = step[STEP_W-1:1];
  assign issue      = (state == ST_TAPS) || (state == ST_GAIN_HI && out_free) ||
                      (state == ST_GAIN_LO);
  assign issue_gain = (state != ST_TAPS);
  assign issue_lo   = (state == ST_TAPS) ? step[0] : (state == ST_GAIN_LO);
  assign hist_re    = (state == ST_TAPS) && !step[0];

  // ring addressing: entry head is the newest history value
  assign hist_raddr = {cur_band, TAP_W'(head[cur_band] + step_tap)};
  assign coef_raddr = {cur_band, step_tap};
  assign head_dec   = TAP_W'(head[cur_band] - 1'b1);
  assign hist_waddr = {cur_band, head_dec};

  // unwritten history reads as zero
  assign h_cur = hist_vq ? hist_q : '0;
  assign h_ext = {{(SUM_W-HIST_W){h_cur[HIST_W-1]}}, h_cur};
  assign w_new = sat_hist(acc);

  // multiplier operands: high half signed, low half unsigned
  always_comb begin
    if (s1_gain) begin
      opb = s1_lo ? {{(OPB_W-SPLIT){1'b0}}, s_sum[SPLIT-1:0]}
                  : {s_sum[SUM_W-1], s_sum[SUM_W-1:SPLIT]};
    end else begin
      opb = s1_lo ? {{(OPB_W-SPLIT){1'b0}}, h_cur[SPLIT-1:0]}
                  : {{(OPB_W-HIST_W+SPLIT){h_cur[HIST_W-1]}}, h_cur[HIST_W-1:SPLIT]};
    end
    opa_ext = s1_gain ? {{(PROD_W-VAL_W){gain_q[VAL_W-1]}}, gain_q}
                      : {{(PROD_W-VAL_W){coef_q[VAL_W-1]}}, coef_q};
    opb_ext = {{(PROD_W-OPB_W){opb[OPB_W-1]}}, opb};
  end

  // recombine the two partial products
  assign full_next = {prod_hi[FULL_W-SPLIT-1:0], {SPLIT{1'b0}}} +
                     {{(FULL_W-PROD_W){prod[PROD_W-1]}}, prod};

  // sequencer, pipeline tags, valid bits and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_bands <= CFG_W'(8);
      cur_band     <= '0;
      last_band    <= '0;
      step         <= '0;
      hist_vq      <= 1'b0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s3_valid     <= 1'b0;
      out_valid    <= 1'b0;
      for (int i = 0; i < NUM_BANDS; i++) begin
        head[i] <= '0;
      end
      for (int i = 0; i < NUM_BANDS*TAPS; i++) begin
        hist_valid[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        active_bands <= cfg_wdata;
      end
      if (hist_re) begin
        hist_vq <= hist_valid[hist_raddr];
      end

      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid && s2_lo;

      // output register
      if (s3_valid && s3_gain) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_take && op == OP_SAMPLE) begin
            cur_band  <= '0;
            last_band <= last_band_of(active_bands);
            step      <= '0;
            state     <= ST_TAPS;
          end
        end
        ST_TAPS: begin
          step <= STEP_W'(step + 1'b1);
          if (step == {STEP_W{1'b1}}) begin
            state <= ST_DRAIN_ACC;
          end
        end
        ST_DRAIN_ACC: begin
          if (pipe_empty) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          hist_valid[hist_waddr] <= 1'b1;
          head[cur_band]         <= head_dec;
          state                  <= ST_GAIN_HI;
        end
        ST_GAIN_HI: begin
          if (out_free) begin
            state <= ST_GAIN_LO;
          end
        end
        ST_GAIN_LO: begin
          state <= ST_DRAIN_OUT;
        end
        ST_DRAIN_OUT: begin
          if (pipe_empty) begin
            if (cur_band == last_band) begin
              state <= ST_IDLE;
            end else begin
              cur_band <= BAND_W'(cur_band + 1'b1);
              step     <= '0;
              state    <= ST_TAPS;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // coefficient and gain memories
  always_ff @(posedge clk) begin
    if (in_take && op == OP_COEF && 32'(band) < NUM_BANDS) begin
      coef_mem[{band, tap}] <= value;
    end
    if (in_take && op == OP_GAIN && 32'(band) < NUM_BANDS) begin
      gain_mem[band] <= value;
    end
    if (hist_re) begin
      coef_q <= coef_mem[coef_raddr];
    end
    if (state == ST_UPDATE) begin
      gain_q <= gain_mem[cur_band];
    end
  end

  // history memory, ring written at the new head
  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      hist_mem[hist_waddr] <= w_new;
    end
    if (hist_re) begin
      hist_q <= hist_mem[hist_raddr];
    end
  end

  // multiply, combine and accumulate stages
  always_ff @(posedge clk) begin
    s1_gain <= issue_gain;
    s1_lo   <= issue_lo;
    s1_tap  <= step_tap;
    s2_gain <= s1_gain;
    s2_lo   <= s1_lo;
    s3_gain <= s2_gain;
    s3_band <= cur_band;
    s3_last <= (cur_band == last_band);

    // sample latch and per-band start of the sums
    if (in_take && op == OP_SAMPLE) begin
      x <= value;
    end
    if ((state == ST_IDLE) || (state == ST_DRAIN_OUT)) begin
      s_acc <= '0;
      if (in_take) begin
        acc <= {{(ACC_W-VAL_W){value[VAL_W-1]}}, value};
      end else begin
        acc <= {{(ACC_W-VAL_W){x[VAL_W-1]}}, x};
      end
    end

    // numerator taps -4, 6, -4, 1 on w2, w4, w6, w8
    if (s1_valid && !s1_gain && !s1_lo) begin
      case (s1_tap)
        3'd1:    s_acc <= s_acc - (h_ext <<< 2);
        3'd3:    s_acc <= s_acc + (h_ext <<< 2) + (h_ext <<< 1);
        3'd5:    s_acc <= s_acc - (h_ext <<< 2);
        3'd7:    s_acc <= s_acc + h_ext;
        default: s_acc <= s_acc;
      endcase
    end

    if (s1_valid) begin
      prod <= opa_ext * opb_ext;
    end
    if (s2_valid) begin
      if (s2_lo) begin
        full <= full_next;
      end else begin
        prod_hi <= prod;
      end
    end

    // subtract feedback term, or form the band output
    if (s3_valid && !s3_gain) begin
      acc <= acc - $signed(full[ACC_W+COEF_FRAC-1:COEF_FRAC]);
    end
    if (s3_valid && s3_gain) begin
      out_band <= s3_band;
      filtered <= sat_out($signed(full[FULL_W-1:GAIN_FRAC]));
      last     <= s3_last;
    end

    if (state == ST_UPDATE) begin
      s_sum <= s_acc + {{(SUM_W-HIST_W){w_new[HIST_W-1]}}, w_new};
    end
  end

  // checks
  `IBF_ASSERT_NOW(a_no_overwrite, s3_valid && s3_gain, !out_valid || !out_stall,
    "band output lands on an unconsumed word")
  `IBF_ASSERT_NOW(a_update_drained, state == ST_UPDATE, !s1_valid && !s2_valid && !s3_valid,
    "history update while products are still in flight")
  `IBF_ASSERT_NEXT(a_halves_paired, s2_valid && !s2_lo, s2_valid && s2_lo,
    "high partial product not followed by its low half")

endmodule

`default_nettype wire

### sim/iir_bandpass_filter_bank_tb.sv
// ----------------------------------------------------------------------------
// iir_bandpass_filter_bank_tb
// Self-checking bench for the bandpass filter bank. A directed table covers
// value extremes, every op, saturation and ignored words, then random words
// run through several active-band settings. Every output word is compared
// against a bit-true model of the bank kept in this file.
// ----------------------------------------------------------------------------
module iir_bandpass_filter_bank_tb
  import ibf_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NONE     = 2'd3;
  localparam int         CYCLE_LIMIT = 1_000_000;
  localparam int         SETTLE_WAIT = 40;
  localparam int         LONG_HOLD   = 500;
  localparam int         PHASES      = 7;
  localparam int         PHASE_WORDS = 28;
  localparam int         QUIET_WORDS = 20;
  localparam int         DIR_ROWS    = 20;
  localparam int         MAX_SHOWN   = 10;

  localparam logic signed [127:0] HIST_HI = (128'sd1 <<< (HIST_W - 1)) - 128'sd1;
  localparam logic signed [127:0] HIST_LO = -(128'sd1 <<< (HIST_W - 1));
  localparam logic signed [127:0] OUT_HI  = (128'sd1 <<< (OUT_W - 1)) - 128'sd1;
  localparam logic signed [127:0] OUT_LO  = -(128'sd1 <<< (OUT_W - 1));

  typedef struct packed {
    logic [1:0]              op;
    logic [BAND_W-1:0]       band;
    logic [TAP_W-1:0]        tap;
    logic signed [VAL_W-1:0] value;
  } word_t;

  typedef struct packed {
    word_t                   w;
    logic                    typed;
    logic signed [OUT_W-1:0] y;
  } dir_row_t;

  typedef struct packed {
    logic [BAND_W-1:0]       band;
    logic signed [OUT_W-1:0] y;
    logic                    last;
  } band_result_t;

  // directed words; bank starts with zero coefficients and gain -1.0
  localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{'{OP_SAMPLE, 3'd0, 3'd0, 32'sh7FFF_FFFF}, 1'b1, -40'sd2147483647},
    '{'{OP_SAMPLE, 3'd0, 3'd0, 32'sh8000_0000}, 1'b1, 40'sd2147483648},
    '{'{OP_SAMPLE, 3'd0, 3'd0, 32'sh0000_0000}, 1'b0, 40'sd0},
    '{'{OP_GAIN,   3'd0, 3'd0, 32'sh7FFF_FFFF}, 1'b0, 40'sd0},
    '{'{OP_GAIN,   3'd7, 3'd0, 32'sh0000_0000}, 1'b0, 40'sd0},
    '{'{OP_COEF,   3'd0, 3'd0, 32'sh7FFF_FFFF}, 1'b0, 40'sd0},
    '{'{OP_COEF,   3'd7, 3'd7, 32'sh8000_0000}, 1'b0, 40'sd0},
    '{'{OP_COEF,   3'd3, 3'd5, 32'sh0080_0000}, 1'b0, 40'sd0},
    '{'{OP_SAMPLE, 3'd0, 3'd0, 32'sh0001_0000}, 1'b0, 40'sd0},
    '{'{OP_SAMPLE, 3'd0, 3'd0, 32'sh8000_0000}, 1'b0, 40'sd0},
    '{'{OP_SAMPLE, 3'd0, 3'd0, 32'sh7FFF_FFFF}, 1'b0, 40'sd0},
    '{'{OP_NONE,   3'd5, 3'd2, 32'shFFFF_FFFF}, 1'b0, 40'sd0},
    '{'{OP_SAMPLE, 3'd7, 3'd7, 32'sh7FFF_FFFF}, 1'b0, 40'sd0},
    '{'{OP_SAMPLE, 3'd2, 3'd1, 32'sh1234_5678}, 1'b0, 40'sd0},
    '{'{OP_GAIN,   3'd3, 3'd0, 32'sh8000_0000}, 1'b0, 40'sd0},
    '{'{OP_COEF,   3'd5, 3'd3, 32'shFF80_0000}, 1'b0, 40'sd0},
    '{'{OP_SAMPLE, 3'd0, 3'd0, 32'shFFFF_FFFF}, 1'b0, 40'sd0},
    '{'{OP_SAMPLE, 3'd0, 3'd0, 32'sh0000_0000}, 1'b0, 40'sd0},
    '{'{OP_NONE,   3'd0, 3'd0, 32'sh0000_0000}, 1'b0, 40'sd0},
    '{'{OP_SAMPLE, 3'd0, 3'd0, 32'sh0000_0001}, 1'b0, 40'sd0}
  };

  localparam logic [CFG_W-1:0] PHASE_BANDS [PHASES] = '{
    4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd8
  };

  logic                    clk       = 1'b0;
  logic                    rst       = 1'b1;
  logic                    cfg_we    = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata = '0;
  logic                    in_valid  = 1'b0;
  logic                    in_stall;
  logic [1:0]              op        = OP_SAMPLE;
  logic [BAND_W-1:0]       band      = '0;
  logic [TAP_W-1:0]        tap       = '0;
  logic signed [VAL_W-1:0] value     = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [BAND_W-1:0]       out_band;
  logic signed [OUT_W-1:0] filtered;
  logic                    last;

  // bank model state
  logic signed [HIST_W-1:0] hist_mem [NUM_BANDS][TAPS];
  logic signed [VAL_W-1:0]  coef_mem [NUM_BANDS][TAPS];
  logic signed [VAL_W-1:0]  gain_mem [NUM_BANDS];
  logic [CFG_W-1:0]         cur_bands = 4'd8;
  band_result_t             band_outputs_due [$];

  int          mismatch_count = 0;
  int unsigned cycle_count    = 0;
  logic        quiet          = 1'b0;
  logic        long_hold_go   = 1'b0;
  logic        long_hold_done = 1'b0;
  int          hold_left      = 0;
  int          free_left      = 0;

  iir_bandpass_filter_bank dut (
    .clk, .rst, .cfg_we, .cfg_wdata,
    .in_valid, .in_stall, .op, .band, .tap, .value,
    .out_valid, .out_stall, .out_band, .filtered, .last
  );

  always #1ns clk = ~clk;

  // floor(a * b / 2^sh)
  function automatic logic signed [127:0] mul_floor(input logic signed [VAL_W-1:0] a,
                                                    input logic signed [127:0] b,
                                                    input int sh);
    logic signed [127:0] wa;
    wa = 128'(a);
    return (wa * b) >>> sh;
  endfunction

  function automatic logic signed [127:0] clamp(input logic signed [127:0] v,
                                                input logic signed [127:0] lo,
                                                input logic signed [127:0] hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // one sample through every active band, queueing the output words
  function automatic void filter_sample(input logic signed [VAL_W-1:0] x,
                                        input logic typed,
                                        input logic signed [OUT_W-1:0] typed_y);
    int                       n;
    int                       b;
    int                       k;
    logic signed [127:0]      acc;
    logic signed [127:0]      s;
    logic signed [127:0]      y;
    logic signed [HIST_W-1:0] w;
    band_result_t             r;
    n = (cur_bands == 0) ? 1 : ((int'(cur_bands) > NUM_BANDS) ? NUM_BANDS : int'(cur_bands));
    for (b = 0; b < n; b++) begin
      acc = 128'(x);
      for (k = 0; k < TAPS; k++) begin
        acc = acc - mul_floor(coef_mem[b][k], 128'(hist_mem[b][k]), COEF_FRAC);
      end
      acc = clamp(acc, HIST_LO, HIST_HI);
      w = acc[HIST_W-1:0];
      s = 128'(w) - 128'sd4 * 128'(hist_mem[b][1]) + 128'sd6 * 128'(hist_mem[b][3])
          - 128'sd4 * 128'(hist_mem[b][5]) + 128'(hist_mem[b][7]);
      y = clamp(mul_floor(gain_mem[b], s, GAIN_FRAC), OUT_LO, OUT_HI);
      for (k = TAPS - 1; k > 0; k--) begin
        hist_mem[b][k] = hist_mem[b][k-1];
      end
      hist_mem[b][0] = w;
      r.band = b[BAND_W-1:0];
      r.y    = typed ? typed_y : y[OUT_W-1:0];
      r.last = (b == n - 1);
      band_outputs_due.push_back(r);
    end
  endfunction

  function automatic word_t random_word();
    word_t w;
    int    pick;
    pick   = $urandom_range(0, 99);
    w.band = BAND_W'($urandom_range(0, NUM_BANDS - 1));
    w.tap  = TAP_W'($urandom_range(0, TAPS - 1));
    w.value = $urandom;
    if (pick < 65) begin
      w.op = OP_SAMPLE;
      if (pick < 4) begin
        w.value = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      end else if (pick >= 12) begin
        w.value = $signed(w.value) >>> 10;
      end
    end else if (pick < 82) begin
      // mostly small taps keep the filters from railing at once
      w.op = OP_COEF;
      if (pick >= 67) begin
        w.value = $signed(w.value) >>> 12;
      end
    end else if (pick < 94) begin
      w.op = OP_GAIN;
      if (pick < 84) begin
        w.value = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      end
    end else begin
      w.op = OP_NONE;
    end
    return w;
  endfunction

  function automatic void flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_SHOWN) begin
      $display("%s", msg);
    end
  endfunction

  // offer one word, optionally after an idle burst, and apply it on acceptance
  task automatic send_word(input word_t w, input logic typed,
                           input logic signed [OUT_W-1:0] typed_y);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= w.op;
    band     <= w.band;
    tap      <= w.tap;
    value    <= w.value;
    do @(posedge clk); while (in_stall !== 1'b0);
    case (w.op)
      OP_SAMPLE: filter_sample(w.value, typed, typed_y);
      OP_COEF:   coef_mem[w.band][w.tap] = w.value;
      OP_GAIN:   gain_mem[w.band] = w.value;
      default: ;
    endcase
  endtask

  // stop offering and wait until every output word is back
  task automatic settle();
    in_valid <= 1'b0;
    while (band_outputs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic set_bands(input logic [CFG_W-1:0] v);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_bands = v;
  endtask

  // stimulus
  initial begin
    word_t w;
    int    b;
    int    k;
    int    i;
    int    ph;
    for (b = 0; b < NUM_BANDS; b++) begin
      gain_mem[b] = '0;
      for (k = 0; k < TAPS; k++) begin
        hist_mem[b][k] = '0;
        coef_mem[b][k] = '0;
      end
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // bring-up load: zero taps, gain -1.0
    for (b = 0; b < NUM_BANDS; b++) begin
      for (k = 0; k < TAPS; k++) begin
        send_word('{OP_COEF, b[BAND_W-1:0], k[TAP_W-1:0], 32'sh0}, 1'b0, '0);
      end
      send_word('{OP_GAIN, b[BAND_W-1:0], 3'd0, 32'sh8000_0000}, 1'b0, '0);
    end

    for (i = 0; i < DIR_ROWS; i++) begin
      send_word(DIRECTED_ROWS[i].w, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].y);
    end

    // fresh random taps and gains for the whole bank
    for (b = 0; b < NUM_BANDS; b++) begin
      for (k = 0; k < TAPS; k++) begin
        w = '{OP_COEF, b[BAND_W-1:0], k[TAP_W-1:0], $signed($urandom) >>> 12};
        send_word(w, 1'b0, '0);
      end
      send_word('{OP_GAIN, b[BAND_W-1:0], 3'd0, $urandom}, 1'b0, '0);
    end

    // random words over several active-band settings
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) begin
        set_bands(4'($urandom_range(0, 15)));
      end else if (ph > 0) begin
        set_bands(PHASE_BANDS[ph]);
      end
      for (i = 0; i < PHASE_WORDS; i++) begin
        if (ph == 0 && i == 10) begin
          long_hold_go <= 1'b1;
        end
        if (ph == 3 && i == 25) begin
          settle();
        end
        if (ph == PHASES - 1 && i == PHASE_WORDS - QUIET_WORDS) begin
          quiet <= 1'b1;
        end
        send_word(random_word(), 1'b0, '0);
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("iir_bandpass_filter_bank_tb: done, clean");
    end else begin
      $display("iir_bandpass_filter_bank_tb: done, errors");
    end
    $finish;
  end

  // receiver back-pressure: random bursts plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (quiet) begin
      out_stall <= 1'b0;
    end else begin
      if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        free_left = 0;
        hold_left = LONG_HOLD;
      end else if (free_left == 0 && hold_left == 0) begin
        free_left = $urandom_range(0, 30);
        hold_left = $urandom_range(1, 10);
      end
      if (free_left > 0) begin
        free_left = free_left - 1;
        out_stall <= 1'b0;
      end else begin
        hold_left = hold_left - 1;
        out_stall <= 1'b1;
      end
    end
  end

  // compare each accepted output word with the oldest one due
  always @(posedge clk) begin
    band_result_t due;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (band_outputs_due.size() == 0) begin
        flag_error($sformatf("unexpected word: band %0d filtered %0d last %0d",
                             out_band, filtered, last));
      end else begin
        due = band_outputs_due.pop_front();
        if (out_band !== due.band || filtered !== due.y || last !== due.last) begin
          flag_error($sformatf("mismatch: exp band %0d filtered %0d last %0d, got %0d %0d %0d",
                               due.band, due.y, due.last, out_band, filtered, last));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("iir_bandpass_filter_bank_tb: done, errors");
      $finish;
    end
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ibf_pkg.sv
rtl/core/iir_bandpass_filter_bank.sv
sim/iir_bandpass_filter_bank_tb.sv
